### sv/pss_pkg.sv
// shared constants and helpers for the pot speed stepper sequencer
package pss_pkg;

    // converter resolution and phase count
    localparam int ADC_BITS    = 10;
    localparam int PHASE_COUNT = 4;

    // field widths and the widths derived from them
    localparam int PERIOD_W = 12;
    localparam int BAND_W   = 8;
    localparam int PHASE_W  = (PHASE_COUNT > 2) ? $clog2(PHASE_COUNT) : 1;
    localparam int COIL_W   = 4;
    localparam int PROD_W   = PERIOD_W + ADC_BITS;
    localparam int IN_DATA_W  = ((ADC_BITS + 7) / 8) * 8;
    localparam int OUT_FLD_W  = COIL_W + PERIOD_W + 1;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // full scale of the converter
    localparam logic [ADC_BITS-1:0] ADC_FULL = {ADC_BITS{1'b1}};

    // register reset values
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = PERIOD_W'(374);
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = PERIOD_W'(3749);
    localparam logic [BAND_W-1:0]   DEAD_BAND_RST  = BAND_W'(15);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 2'd2;

    // item kinds carried in tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // one-hot coil drive, phases past the fourth drive nothing
    function automatic logic [COIL_W-1:0] coil_decode(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        pat = '0;
        for (int i = 0; i < COIL_W; i++) begin
            if (int'(phase) == i) pat[i] = 1'b1;
        end
        return pat;
    endfunction

endpackage

### sv/pot_speed_stepper_sequencer.sv
// pot speed stepper sequencer: sample to period mapping, tick counter, coil phase
// Throughput: one word per cycle; a three-stage pipeline (product, quotient,
// state update) feeds an output register, and stalls only back up from m_tready.
// Reset: asynchronous active low; configuration and state registers return to their
// reset values, period 374, tick count zero, phase at the first coil, and the pipeline empties.
module pot_speed_stepper_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pss_pkg::PERIOD_W-1:0]      cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pss_pkg::IN_DATA_W-1:0]     s_tdata,   // adc_sample, zero pad
    input  logic                              s_tuser,   // command
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pss_pkg::OUT_DATA_W-1:0]    m_tdata    // coil_pattern, period_in_use, stepped, zero pad
);

    localparam int AB = pss_pkg::ADC_BITS;
    localparam int PW = pss_pkg::PERIOD_W;
    localparam int XW = pss_pkg::PROD_W;

    // configuration registers
    logic [PW-1:0]                 min_period_reg;
    logic [PW-1:0]                 max_period_reg;
    logic [pss_pkg::BAND_W-1:0]    dead_band_reg;

    // pipeline valids
    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic ld1, ld2, ld3, ld_o;

    // stage payloads
    logic          cmd1_reg, cmd2_reg, cmd3_reg;
    logic [AB-1:0] smp1_reg;
    logic [XW-1:0] prod2_reg;
    logic          up2_reg;
    logic [PW-1:0] cand3_reg;

    // block state
    logic [PW-1:0]                  step_period_reg, step_period_next;
    logic [PW-1:0]                  tick_count_reg, tick_count_next;
    logic [pss_pkg::PHASE_W-1:0]    coil_phase_reg, coil_phase_next;
    logic                           stepped_next;

    // result register
    logic [pss_pkg::COIL_W-1:0]     coil_out_reg;
    logic [PW-1:0]                  period_out_reg;
    logic                           stepped_out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= pss_pkg::MIN_PERIOD_RST;
            max_period_reg <= pss_pkg::MAX_PERIOD_RST;
            dead_band_reg  <= pss_pkg::DEAD_BAND_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pss_pkg::REG_MIN_PERIOD: min_period_reg <= cfg_wdata;
                pss_pkg::REG_MAX_PERIOD: max_period_reg <= cfg_wdata;
                pss_pkg::REG_DEAD_BAND:  dead_band_reg  <= cfg_wdata[pss_pkg::BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // stage load enables, each stage moves when the next one has room
    assign ld_o     = !ov_reg || m_tready;
    assign ld3      = !v3_reg || ld_o;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= s_tvalid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld_o) ov_reg <= v3_reg;
        end
    end

    // stage 1 to 2: span times sample
    logic          up_dir;
    logic [PW-1:0] span;
    assign up_dir = (max_period_reg >= min_period_reg);
    assign span   = up_dir ? (max_period_reg - min_period_reg)
                           : (min_period_reg - max_period_reg);

    // stage 2 to 3: divide by full scale, reciprocal estimate plus one correction
    logic [XW:0]   q_sum;
    logic [PW:0]   q_est;
    logic [XW:0]   q_back;
    logic [XW:0]   q_rem;
    logic [PW-1:0] q_fin;
    logic [PW-1:0] cand;
    always_comb
    begin
        q_sum  = {1'b0, prod2_reg} + {1'b0, (prod2_reg >> AB)};
        q_est  = q_sum[AB+PW:AB];
        q_back = ((XW+1)'(q_est) << AB) - (XW+1)'(q_est);
        q_rem  = {1'b0, prod2_reg} - q_back;
        if (q_rem >= (XW+1)'(pss_pkg::ADC_FULL))
            q_fin = q_est[PW-1:0] + PW'(1);
        else
            q_fin = q_est[PW-1:0];
        cand = up2_reg ? (min_period_reg + q_fin) : (min_period_reg - q_fin);
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            cmd1_reg <= s_tuser;
            smp1_reg <= s_tdata[AB-1:0];
        end
        if (ld2)
        begin
            cmd2_reg  <= cmd1_reg;
            prod2_reg <= XW'(span) * XW'(smp1_reg);
            up2_reg   <= up_dir;
        end
        if (ld3)
        begin
            cmd3_reg  <= cmd2_reg;
            cand3_reg <= cand;
        end
    end

    // stage 3: dead band check, tick count and phase advance
    logic [PW-1:0] diff;
    logic [PW:0]   tick_inc;
    always_comb
    begin
        step_period_next = step_period_reg;
        tick_count_next  = tick_count_reg;
        coil_phase_next  = coil_phase_reg;
        stepped_next     = 1'b0;
        diff     = (cand3_reg >= step_period_reg) ? (cand3_reg - step_period_reg)
                                                  : (step_period_reg - cand3_reg);
        tick_inc = {1'b0, tick_count_reg} + (PW+1)'(1);
        if (cmd3_reg == pss_pkg::CMD_SAMPLE)
        begin
            if (diff >= PW'(dead_band_reg))
            begin
                step_period_next = cand3_reg;
                if (cand3_reg < tick_count_reg)
                    tick_count_next = '0;
            end
        end
        else
        begin
            if (tick_inc >= {1'b0, step_period_reg})
            begin
                tick_count_next = '0;
                stepped_next    = 1'b1;
                if (coil_phase_reg == pss_pkg::PHASE_W'(pss_pkg::PHASE_COUNT - 1))
                    coil_phase_next = '0;
                else
                    coil_phase_next = coil_phase_reg + pss_pkg::PHASE_W'(1);
            end
            else
            begin
                tick_count_next = tick_inc[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg <= pss_pkg::MIN_PERIOD_RST;
            tick_count_reg  <= '0;
            coil_phase_reg  <= '0;
        end
        else if (ld_o && v3_reg)
        begin
            step_period_reg <= step_period_next;
            tick_count_reg  <= tick_count_next;
            coil_phase_reg  <= coil_phase_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ld_o && v3_reg)
        begin
            coil_out_reg    <= pss_pkg::coil_decode(coil_phase_next);
            period_out_reg  <= step_period_next;
            stepped_out_reg <= stepped_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = pss_pkg::OUT_DATA_W'({stepped_out_reg, period_out_reg, coil_out_reg});

endmodule

### verif/tb_pot_speed_stepper_sequencer.sv
// self-checking testbench for the pot speed stepper sequencer
module tb_pot_speed_stepper_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASE_ITEMS = 48;

    // one input word: kind and converter reading
    typedef struct packed {
        logic                         cmd;
        logic [pss_pkg::ADC_BITS-1:0] sample;
    } motor_item_t;

    // one result word
    typedef struct packed {
        logic [pss_pkg::COIL_W-1:0]   coils;
        logic [pss_pkg::PERIOD_W-1:0] period;
        logic                         stepped;
    } drive_word_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pss_pkg::PERIOD_W-1:0]   cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [pss_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [pss_pkg::OUT_DATA_W-1:0] m_tdata;

    pot_speed_stepper_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // words waiting to be sent and drive words still owed by the block
    motor_item_t pending_words[$];
    drive_word_t owed_drive[$];

    // shadow of the block: registers and motor state
    logic [pss_pkg::PERIOD_W-1:0] min_reg;
    logic [pss_pkg::PERIOD_W-1:0] max_reg;
    logic [pss_pkg::BAND_W-1:0]   band_reg;
    logic [pss_pkg::PERIOD_W-1:0] kept_period;
    int unsigned                  tick_cnt;
    int unsigned                  phase_idx;

    int  errors       = 0;
    int  words_seen   = 0;
    bit  idle_on      = 1'b0;
    bit  tx_fire      = 1'b0;
    bit  rx_fire      = 1'b0;
    int  tx_gap       = 0;
    int  rx_gap       = 0;
    int  hold_trigger = 0;
    int  hold_seen    = 0;
    int  hold_left    = 0;
    int  quiet_cycles = 0;

    // speed mapping, dead band, tick counting and phase advance for one word
    function automatic drive_word_t advance_motor(motor_item_t it);
        drive_word_t w;
        int unsigned span;
        int unsigned cand;
        int unsigned diff;
        int unsigned full;
        full      = pss_pkg::ADC_FULL;
        w.stepped = 1'b0;
        if (it.cmd == pss_pkg::CMD_SAMPLE)
        begin
            if (max_reg >= min_reg)
            begin
                span = max_reg - min_reg;
                cand = min_reg + (span * it.sample) / full;
            end
            else
            begin
                span = min_reg - max_reg;
                cand = min_reg - (span * it.sample) / full;
            end
            diff = (cand >= kept_period) ? cand - kept_period : kept_period - cand;
            if (diff >= band_reg)
            begin
                kept_period = cand[pss_pkg::PERIOD_W-1:0];
                // a shorter period under the running count restarts the count
                if (kept_period < tick_cnt)
                    tick_cnt = 0;
            end
        end
        else
        begin
            tick_cnt++;
            if (tick_cnt >= kept_period)
            begin
                tick_cnt  = 0;
                phase_idx = (phase_idx + 1) % pss_pkg::PHASE_COUNT;
                w.stepped = 1'b1;
            end
        end
        w.coils  = (phase_idx < pss_pkg::COIL_W) ? pss_pkg::COIL_W'(1 << phase_idx) : '0;
        w.period = kept_period;
        return w;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("ERROR: word %0d %s is %0h, expected %0h", words_seen, field, got, want);
        errors++;
    endtask

    // register write while the block is idle, shadow follows at once
    task automatic cfg_write(input logic [pss_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= pss_pkg::PERIOD_W'(value);
        if (idx == pss_pkg::REG_MIN_PERIOD)
            min_reg = pss_pkg::PERIOD_W'(value);
        else if (idx == pss_pkg::REG_MAX_PERIOD)
            max_reg = pss_pkg::PERIOD_W'(value);
        else if (idx == pss_pkg::REG_DEAD_BAND)
            band_reg = pss_pkg::BAND_W'(value);
    endtask

    task automatic cfg_all(input int unsigned lo, input int unsigned hi, input int unsigned band);
        cfg_write(pss_pkg::REG_MIN_PERIOD, lo);
        cfg_write(pss_pkg::REG_MAX_PERIOD, hi);
        cfg_write(pss_pkg::REG_DEAD_BAND, band);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_word(input logic cmd, input int unsigned sample);
        motor_item_t it;
        it.cmd    = cmd;
        it.sample = pss_pkg::ADC_BITS'(sample);
        pending_words.push_back(it);
    endtask

    // wait until every word is sent and every drive word has come back
    task automatic settle();
        while (pending_words.size() != 0 || s_tvalid || owed_drive.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // sender: random per word gap after acceptance while idle_on is set
    always @(negedge clk)
    begin : send_proc
        motor_item_t nx;
        if (rst_n)
        begin
            if (s_tvalid && !tx_fire)
            begin
                // still waiting for acceptance
            end
            else if (tx_gap > 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end
            else if (pending_words.size() != 0)
            begin
                nx = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nx.cmd;
                s_tdata  <= pss_pkg::IN_DATA_W'(nx.sample);
                tx_gap   = idle_on ? $urandom_range(0, 3) : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random per word stall while idle_on is set, plus a long hold on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_trigger != hold_seen)
            begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (m_tready && !rx_fire)
            begin
                // ready until a word arrives
            end
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_gap = idle_on ? $urandom_range(0, 3) : 0;
            end
        end
    end

    // monitor: check results, predict accepted inputs
    always @(posedge clk)
    begin : watch_proc
        drive_word_t want;
        drive_word_t got;
        motor_item_t it;
        if (rst_n)
        begin
            tx_fire <= s_tvalid && s_tready;
            rx_fire <= m_tvalid && m_tready;
            if (m_tvalid && m_tready)
            begin
                got.coils   = m_tdata[pss_pkg::COIL_W-1:0];
                got.period  = m_tdata[pss_pkg::COIL_W+pss_pkg::PERIOD_W-1:pss_pkg::COIL_W];
                got.stepped = m_tdata[pss_pkg::COIL_W+pss_pkg::PERIOD_W];
                if (owed_drive.size() == 0)
                begin
                    report_mismatch("unexpected word", got, 0);
                end
                else
                begin
                    want = owed_drive.pop_front();
                    if (got.coils !== want.coils)
                        report_mismatch("coil_pattern", got.coils, want.coils);
                    if (got.period !== want.period)
                        report_mismatch("period_in_use", got.period, want.period);
                    if (got.stepped !== want.stepped)
                        report_mismatch("stepped", got.stepped, want.stepped);
                end
                words_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                it.cmd    = s_tuser;
                it.sample = s_tdata[pss_pkg::ADC_BITS-1:0];
                owed_drive.push_back(advance_motor(it));
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned lo;
        int unsigned hi;
        int unsigned band;
        min_reg     = pss_pkg::MIN_PERIOD_RST;
        max_reg     = pss_pkg::MAX_PERIOD_RST;
        band_reg    = pss_pkg::DEAD_BAND_RST;
        kept_period = pss_pkg::MIN_PERIOD_RST;
        tick_cnt    = 0;
        phase_idx   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset settings: sample extremes, change inside the dead band, alternating bits
        push_word(pss_pkg::CMD_SAMPLE, 0);
        push_word(pss_pkg::CMD_SAMPLE, 1023);
        push_word(pss_pkg::CMD_SAMPLE, 1);
        push_word(pss_pkg::CMD_SAMPLE, 0);
        push_word(pss_pkg::CMD_TICK, 1023);
        push_word(pss_pkg::CMD_TICK, 0);
        push_word(pss_pkg::CMD_SAMPLE, 'h2AA);
        push_word(pss_pkg::CMD_SAMPLE, 'h155);
        push_word(pss_pkg::CMD_TICK, 'h2AA);
        settle();

        // reversed limits, zero band, period lowered under the running count
        cfg_all(3, 0, 0);
        push_word(pss_pkg::CMD_SAMPLE, 0);
        push_word(pss_pkg::CMD_TICK, 0);
        push_word(pss_pkg::CMD_TICK, 0);
        push_word(pss_pkg::CMD_TICK, 0);
        push_word(pss_pkg::CMD_TICK, 0);
        push_word(pss_pkg::CMD_TICK, 0);
        push_word(pss_pkg::CMD_SAMPLE, 1023);
        push_word(pss_pkg::CMD_TICK, 0);
        push_word(pss_pkg::CMD_TICK, 0);
        push_word(pss_pkg::CMD_SAMPLE, 512);
        push_word(pss_pkg::CMD_TICK, 0);
        push_word(pss_pkg::CMD_TICK, 0);
        settle();

        // random phases, extreme settings first
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin lo = 0;    hi = 4095; band = 255; end
                1: begin lo = 4095; hi = 0;    band = 0;   end
                2: begin lo = 4095; hi = 4095; band = 0;   end
                3: begin lo = 0;    hi = 0;    band = 255; end
                default:
                begin
                    lo   = $urandom_range(0, 12);
                    hi   = $urandom_range(0, 40);
                    band = $urandom_range(0, 6);
                end
            endcase
            cfg_all(lo, hi, band);
            idle_on = ($urandom_range(0, 3) != 0) && (p != 5);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_word(pss_pkg::CMD_SAMPLE, $urandom_range(0, 1023));
                else
                    push_word(pss_pkg::CMD_TICK, $urandom_range(0, 1023));
            end
            // long receiver hold so the pipeline fills and backs up the input
            if (p == 4)
                hold_trigger++;
            settle();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
sv/pss_pkg.sv
sv/pot_speed_stepper_sequencer.sv
verif/tb_pot_speed_stepper_sequencer.sv
